>>> src/abpf_pkg.sv
// shared types and constants for the affine background pixel fetch
`default_nettype none
package abpf_pkg;

	localparam int VRAM_WORDS = 32768;
	localparam int ADDR_W     = $clog2(VRAM_WORDS);
	localparam int WORD_W     = 16;
	localparam int MAT_W      = 16;
	localparam int POS_W      = 13;
	// mirrored screen coordinate plus scroll minus centre
	localparam int DELTA_W    = 15;
	localparam int PROD_W     = MAT_W + DELTA_W;
	localparam int SUM_W      = 32;
	localparam int PLANE_W    = 10;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y = 3'd7;

	// repeat modes
	localparam logic [1:0] REP_WRAP    = 2'd0;
	localparam logic [1:0] REP_CLEAR_A = 2'd1;
	localparam logic [1:0] REP_CLEAR_B = 2'd2;
	localparam logic [1:0] REP_FILL    = 2'd3;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic signed [MAT_W-1:0] matrix_a;
		logic signed [MAT_W-1:0] matrix_b;
		logic signed [MAT_W-1:0] matrix_c;
		logic signed [MAT_W-1:0] matrix_d;
		logic signed [POS_W-1:0] centre_x;
		logic signed [POS_W-1:0] centre_y;
		logic signed [POS_W-1:0] scroll_x;
		logic signed [POS_W-1:0] scroll_y;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] vram_addr;
		logic [WORD_W-1:0] vram_data;
		logic [7:0]        screen_x;
		logic [7:0]        screen_line;
		logic              hflip;
		logic              vflip;
		logic [1:0]        repeat_mode;
	} in_item_t;

	// transformed item handed to the memory stages
	typedef struct packed {
		logic              valid;
		logic              is_write;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic [ADDR_W-1:0] map_addr;
		logic [5:0]        fine;
		logic              use_map;
		logic              drawn;
	} xform_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] pixel_index;
		logic       drawn;
	} result_t;

endpackage
`default_nettype wire

>>> src/abpf_transform.sv
// mirror, scroll and affine transform stages (stages 1 to 3)
`default_nettype none
module abpf_transform (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire abpf_pkg::in_item_t in_item,
	input  wire abpf_pkg::cfg_t    cfg,
	output abpf_pkg::xform_t       xout
);
	import abpf_pkg::*;

	logic [7:0]                sx;
	logic [7:0]                sy;
	logic signed [DELTA_W-1:0] dx;
	logic signed [DELTA_W-1:0] dy;

	logic                      valid_s1;
	in_item_t                  item_s1;
	logic signed [DELTA_W-1:0] dx_s1;
	logic signed [DELTA_W-1:0] dy_s1;

	logic                      valid_s2;
	in_item_t                  item_s2;
	logic signed [PROD_W-1:0]  ax_s2;
	logic signed [PROD_W-1:0]  by_s2;
	logic signed [PROD_W-1:0]  cx_s2;
	logic signed [PROD_W-1:0]  dy_s2;

	logic signed [SUM_W-1:0]   sum_x;
	logic signed [SUM_W-1:0]   sum_y;
	logic                      on_plane;
	logic                      use_map;
	logic [PLANE_W-1:0]        ux;
	logic [PLANE_W-1:0]        uy;

	xform_t                    xform_s3;

	// mirroring 255 - v is the bitwise complement
	assign sx = in_item.hflip ? ~in_item.screen_x : in_item.screen_x;
	assign sy = in_item.vflip ? ~in_item.screen_line : in_item.screen_line;
	assign dx = DELTA_W'($signed({1'b0, sx})) + DELTA_W'(cfg.scroll_x)
		- DELTA_W'(cfg.centre_x);
	assign dy = DELTA_W'($signed({1'b0, sy})) + DELTA_W'(cfg.scroll_y)
		- DELTA_W'(cfg.centre_y);

	// centre enters the sum scaled by 256
	assign sum_x = SUM_W'(ax_s2) + SUM_W'(by_s2)
		+ SUM_W'($signed({cfg.centre_x, {FRAC_W{1'b0}}}));
	assign sum_y = SUM_W'(cx_s2) + SUM_W'(dy_s2)
		+ SUM_W'($signed({cfg.centre_y, {FRAC_W{1'b0}}}));

	// floor divide by 256 is the bits above the fraction
	assign ux       = sum_x[FRAC_W+PLANE_W-1:FRAC_W];
	assign uy       = sum_y[FRAC_W+PLANE_W-1:FRAC_W];
	assign on_plane = (sum_x[SUM_W-1:FRAC_W+PLANE_W] == '0)
		&& (sum_y[SUM_W-1:FRAC_W+PLANE_W] == '0);
	assign use_map  = on_plane || (item_s2.repeat_mode == REP_WRAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			xform_s3.valid <= 1'b0;
		end else if (en) begin
			valid_s1       <= in_valid;
			valid_s2       <= valid_s1;
			xform_s3.valid <= valid_s2;

			item_s1 <= in_item;
			dx_s1   <= dx;
			dy_s1   <= dy;

			item_s2 <= item_s1;
			ax_s2   <= cfg.matrix_a * dx_s1;
			by_s2   <= cfg.matrix_b * dy_s1;
			cx_s2   <= cfg.matrix_c * dx_s1;
			dy_s2   <= cfg.matrix_d * dy_s1;

			xform_s3.is_write <= (item_s2.kind == KIND_WRITE);
			xform_s3.waddr    <= item_s2.vram_addr;
			xform_s3.wdata    <= item_s2.vram_data;
			xform_s3.map_addr <= ADDR_W'({uy[PLANE_W-1:3], ux[PLANE_W-1:3]});
			xform_s3.fine     <= {uy[2:0], ux[2:0]};
			xform_s3.use_map  <= use_map;
			xform_s3.drawn    <= use_map || (item_s2.repeat_mode == REP_FILL);
		end
	end

	assign xout = xform_s3;

endmodule
`default_nettype wire

>>> src/abpf_fetch.sv
// video memory with map and pixel read stages (stages 4 and 5)
`default_nettype none
module abpf_fetch (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire abpf_pkg::xform_t xin,
	output abpf_pkg::result_t     res
);
	import abpf_pkg::*;

	logic [WORD_W-1:0] vram [VRAM_WORDS];

	logic              valid_s4;
	logic [WORD_W-1:0] map_s4;
	logic [5:0]        fine_s4;
	logic              use_map_s4;
	logic              drawn_s4;

	logic              valid_s5;
	logic [WORD_W-1:0] word_s5;
	logic              drawn_s5;

	logic [ADDR_W-1:0] pix_addr;

	// outside the plane in fill mode the pixel comes from tile zero
	assign pix_addr = ADDR_W'({use_map_s4 ? map_s4[7:0] : 8'h00, fine_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= xin.valid && !xin.is_write;
			valid_s5 <= valid_s4;
		end
	end

	// a pixel read in the same cycle as a later write sees the old word
	always_ff @(posedge clk) begin
		if (en) begin
			if (xin.valid && xin.is_write) begin
				vram[xin.waddr] <= xin.wdata;
			end
			map_s4  <= vram[xin.map_addr];
			word_s5 <= vram[pix_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fine_s4    <= xin.fine;
			use_map_s4 <= xin.use_map;
			drawn_s4   <= xin.drawn;
			drawn_s5   <= drawn_s4;
		end
	end

	assign res.valid       = valid_s5;
	assign res.drawn       = drawn_s5;
	assign res.pixel_index = drawn_s5 ? word_s5[WORD_W-1:8] : 8'h00;

endmodule
`default_nettype wire

>>> src/affine_background_pixel_fetch.sv
// top level: configuration registers, pipeline and output skid stage
// Affine background pixel fetch. Takes one item per clock while the skid
// register is empty: a video memory word write (tuser high) or a pixel
// request (tuser low), and returns one result per pixel request and none
// per write. The path is five register stages (mirror and scroll, matrix
// multiply, sum and range check, tile map read, pixel read) followed by an
// output register; the rate is one item per cycle, set by the map and pixel
// reads of the 32K x 16 video memory. A skid register behind the output
// keeps the input open while one result waits.
// Configuration writes are always accepted and should only be made while
// no pixel is in flight. Video memory has no reset: every word read must
// have been written first.
`default_nettype none
module affine_background_pixel_fetch (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// vram_addr, vram_data, screen_x, screen_line, hflip, vflip, repeat_mode
	input  wire logic [55:0]                     s_tdata,
	// kind
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// pixel_index
	output logic [7:0]                           m_tdata,
	// drawn
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [abpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                     cfg_data
);
	import abpf_pkg::*;

	cfg_t     cfg_q;
	in_item_t in_item;
	xform_t   xform;
	result_t  res;
	result_t  out_q;
	result_t  skid_q;
	logic     en;
	logic     push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{matrix_a: 16'sd256, matrix_b: 16'sd0, matrix_c: 16'sd0,
				matrix_d: 16'sd256, centre_x: 13'sd0, centre_y: 13'sd0,
				scroll_x: 13'sd0, scroll_y: 13'sd0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MATRIX_A: cfg_q.matrix_a <= cfg_data;
				REG_MATRIX_B: cfg_q.matrix_b <= cfg_data;
				REG_MATRIX_C: cfg_q.matrix_c <= cfg_data;
				REG_MATRIX_D: cfg_q.matrix_d <= cfg_data;
				REG_CENTRE_X: cfg_q.centre_x <= cfg_data[POS_W-1:0];
				REG_CENTRE_Y: cfg_q.centre_y <= cfg_data[POS_W-1:0];
				REG_SCROLL_X: cfg_q.scroll_x <= cfg_data[POS_W-1:0];
				REG_SCROLL_Y: cfg_q.scroll_y <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_item.kind        = s_tuser;
	assign in_item.vram_addr   = s_tdata[14:0];
	assign in_item.vram_data   = s_tdata[30:15];
	assign in_item.screen_x    = s_tdata[38:31];
	assign in_item.screen_line = s_tdata[46:39];
	assign in_item.hflip       = s_tdata[47];
	assign in_item.vflip       = s_tdata[48];
	assign in_item.repeat_mode = s_tdata[50:49];

	// the whole pipeline moves together while the skid register is empty
	assign en       = !skid_q.valid;
	assign s_tready = en;
	assign push     = en && res.valid;

	abpf_transform u_transform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.xout     (xform)
	);

	abpf_fetch u_fetch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.xin    (xform),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q.valid  <= 1'b0;
			skid_q.valid <= 1'b0;
		end else if (out_q.valid && m_tready) begin
			if (skid_q.valid) begin
				out_q        <= skid_q;
				skid_q.valid <= 1'b0;
			end else if (push) begin
				out_q <= res;
			end else begin
				out_q.valid <= 1'b0;
			end
		end else if (!out_q.valid) begin
			if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			// output still held, park the new result
			skid_q <= res;
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = out_q.pixel_index;
	assign m_tuser  = out_q.drawn;

endmodule
`default_nettype wire
